// File: src/recursive_nco_complex_mixer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the recursive NCO complex mixer
// Each macro expands to a labelled concurrent assertion, or to nothing when
// assertions are switched out of the build.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_NCO_COMPLEX_MIXER_UNIT_MACROS_SVH
`define RECURSIVE_NCO_COMPLEX_MIXER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define RNCO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define RNCO_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RNCO_ASSERT(lbl, clk, rst, prop, msg)

`define RNCO_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

// File: src/rnco_pkg.sv
// ----------------------------------------------------------------------------
// rnco_pkg
// Widths, codes, types and helper functions shared by the recursive NCO
// complex mixer: micro-operation codes, register indexes and saturation.
// ----------------------------------------------------------------------------
package rnco_pkg;

   // Data formats
   localparam int SAMPLE_BITS   = 16;
   localparam int OSC_BITS      = 32;
   localparam int OSC_FRAC_BITS = 30;
   localparam int PROD_BITS     = 2 * OSC_BITS;
   localparam int ACC_BITS      = PROD_BITS + 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [OSC_BITS-1:0]    osc_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   // Oscillator constants: 1.0 and the gain target 1.95 (rounded half up)
   localparam osc_type ONE_OSC = OSC_BITS'(64'sd1 <<< OSC_FRAC_BITS);
   localparam acc_type K195    =
      ACC_BITS'(((64'sd39 <<< OSC_FRAC_BITS) + 64'sd10) / 64'sd20);

   // Saturation bounds held at accumulator width
   localparam acc_type OSC_HI =
      {{(ACC_BITS-OSC_BITS+1){1'b0}}, {(OSC_BITS-1){1'b1}}};
   localparam acc_type OSC_LO =
      {{(ACC_BITS-OSC_BITS+1){1'b1}}, {(OSC_BITS-1){1'b0}}};
   localparam acc_type SMP_HI =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam acc_type SMP_LO =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // Configuration port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   localparam csr_addr_type REG_BYPASS  = 2'd0;
   localparam csr_addr_type REG_ROT_COS = 2'd1;
   localparam csr_addr_type REG_ROT_SIN = 2'd2;

   // Multiplier operand pairs
   localparam logic [3:0] MUL_NONE   = 4'd0;
   localparam logic [3:0] MUL_PR_PR  = 4'd1;
   localparam logic [3:0] MUL_PI_PI  = 4'd2;
   localparam logic [3:0] MUL_PR_RC  = 4'd3;
   localparam logic [3:0] MUL_PI_RS  = 4'd4;
   localparam logic [3:0] MUL_PR_RS  = 4'd5;
   localparam logic [3:0] MUL_PI_RC  = 4'd6;
   localparam logic [3:0] MUL_G_ORE  = 4'd7;
   localparam logic [3:0] MUL_ORE_SR = 4'd8;
   localparam logic [3:0] MUL_OIM_SI = 4'd9;
   localparam logic [3:0] MUL_G_OIM  = 4'd10;
   localparam logic [3:0] MUL_ORE_SI = 4'd11;
   localparam logic [3:0] MUL_OIM_SR = 4'd12;

   // Accumulator operations
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   // Destinations for a finished accumulation
   localparam logic [2:0] DST_NONE   = 3'd0;
   localparam logic [2:0] DST_G      = 3'd1;
   localparam logic [2:0] DST_OSC_RE = 3'd2;
   localparam logic [2:0] DST_OSC_IM = 3'd3;
   localparam logic [2:0] DST_PH_RE  = 3'd4;
   localparam logic [2:0] DST_PH_IM  = 3'd5;
   localparam logic [2:0] DST_Y_RE   = 3'd6;
   localparam logic [2:0] DST_Y_IM   = 3'd7;

   // Sequence: twelve product issues, then the remaining steps drain the pipe
   localparam int NUM_STEPS = 14;
   localparam int STEP_BITS = $clog2(NUM_STEPS);

   typedef logic [STEP_BITS-1:0] step_type;

   typedef struct packed {
      logic [3:0] mul_sel;
      logic [1:0] acc_op;
      logic [2:0] dst;
   } mop_type;

   typedef struct packed {
      logic    take_sample;
      logic    publish;
      mop_type mop;
   } cmd_type;

   typedef struct packed {
      logic bypass;
   } stat_type;

   localparam mop_type MOP_IDLE = '{MUL_NONE, ACC_HOLD, DST_NONE};

   // Micro-operation for each step of one mixed sample
   function automatic mop_type step_mop(input step_type step);
      mop_type m;
      m = MOP_IDLE;
      case (step)
         STEP_BITS'(0):  m = '{MUL_PR_PR,  ACC_LOAD, DST_NONE};
         STEP_BITS'(1):  m = '{MUL_PI_PI,  ACC_ADD,  DST_G};
         STEP_BITS'(2):  m = '{MUL_PR_RC,  ACC_LOAD, DST_NONE};
         STEP_BITS'(3):  m = '{MUL_PI_RS,  ACC_SUB,  DST_OSC_RE};
         STEP_BITS'(4):  m = '{MUL_PR_RS,  ACC_LOAD, DST_NONE};
         STEP_BITS'(5):  m = '{MUL_PI_RC,  ACC_ADD,  DST_OSC_IM};
         STEP_BITS'(6):  m = '{MUL_G_ORE,  ACC_LOAD, DST_PH_RE};
         STEP_BITS'(7):  m = '{MUL_ORE_SR, ACC_LOAD, DST_NONE};
         STEP_BITS'(8):  m = '{MUL_OIM_SI, ACC_SUB,  DST_Y_RE};
         STEP_BITS'(9):  m = '{MUL_G_OIM,  ACC_LOAD, DST_PH_IM};
         STEP_BITS'(10): m = '{MUL_ORE_SI, ACC_LOAD, DST_NONE};
         STEP_BITS'(11): m = '{MUL_OIM_SR, ACC_ADD,  DST_Y_IM};
         default:        m = MOP_IDLE;
      endcase
      return m;
   endfunction

   // Clamp an accumulator-width value to the oscillator range
   function automatic osc_type sat_osc(input acc_type x);
      osc_type r;
      if (x > OSC_HI) begin
         r = OSC_HI[OSC_BITS-1:0];
      end else if (x < OSC_LO) begin
         r = OSC_LO[OSC_BITS-1:0];
      end else begin
         r = x[OSC_BITS-1:0];
      end
      return r;
   endfunction

   // Clamp an accumulator-width value to the sample range
   function automatic sample_type sat_sample(input acc_type x);
      sample_type r;
      if (x > SMP_HI) begin
         r = SMP_HI[SAMPLE_BITS-1:0];
      end else if (x < SMP_LO) begin
         r = SMP_LO[SAMPLE_BITS-1:0];
      end else begin
         r = x[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/rnco_if.sv
// ----------------------------------------------------------------------------
// rnco channel interfaces
// Valid/ready channels for input samples, mixed results and register writes.
// ----------------------------------------------------------------------------
interface rnco_req_if;
   import rnco_pkg::*;

   logic       valid;
   logic       ready;
   sample_type in_re;
   sample_type in_im;

   modport source (output valid, output in_re, output in_im, input ready);
   modport sink   (input valid, input in_re, input in_im, output ready);
endinterface

interface rnco_rsp_if;
   import rnco_pkg::*;

   logic       valid;
   logic       ready;
   sample_type out_re;
   sample_type out_im;

   modport source (output valid, output out_re, output out_im, input ready);
   modport sink   (input valid, input out_re, input out_im, output ready);
endinterface

interface rnco_csr_if;
   import rnco_pkg::*;

   logic         valid;
   logic         ready;
   csr_addr_type addr;
   csr_data_type wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: src/recursive_nco_complex_mixer_unit.sv
// ----------------------------------------------------------------------------
// recursive_nco_complex_mixer_unit
// Complex mixer driven by a recursive quadrature oscillator with gain
// correction, Q1.15 samples and a Q2.30 oscillator.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload               Handshake
//  req_bus  in   in_re, in_im          valid/ready, sample to mix
//  rsp_bus  out  out_re, out_im        valid/ready, mixed sample
//  csr_bus  in   addr, wdata           valid/ready, register write
//
//  A mixed sample is stepped through the whole sequence and published before
//  the next sample is accepted. The twelve products share one registered
//  32x32 multiplier, one product per cycle.
//  In bypass a transaction goes from acceptance straight to publishing.
//  Reset restores bypass, a step of 1.0 and the phasor (1.0, 0).
//  A result waits in the output register while the next sample is taken;
//  the sequencer stalls at the hand-over only while that register is full.
// ----------------------------------------------------------------------------
module recursive_nco_complex_mixer_unit (
   input  logic        clock,
   input  logic        reset,
   rnco_req_if.sink    req_bus,
   rnco_rsp_if.source  rsp_bus,
   rnco_csr_if.sink    csr_bus
);
   import rnco_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_we;

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;
   assign csr_we        = csr_bus.valid;

   rnco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rnco_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_re     (req_bus.in_re),
      .in_im     (req_bus.in_im),
      .out_re    (rsp_bus.out_re),
      .out_im    (rsp_bus.out_im),
      .csr_we    (csr_we),
      .csr_addr  (csr_bus.addr),
      .csr_wdata (csr_bus.wdata)
   );

endmodule

// File: src/rnco_datapath.sv
// ----------------------------------------------------------------------------
// rnco_datapath
// Configuration and phasor registers, one shared 32x32 multiplier with a
// registered product, an accumulator and the saturating write-back stage.
// ----------------------------------------------------------------------------
module rnco_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rnco_pkg::cmd_type     cmd,
   output rnco_pkg::stat_type    stat,
   input  rnco_pkg::sample_type  in_re,
   input  rnco_pkg::sample_type  in_im,
   output rnco_pkg::sample_type  out_re,
   output rnco_pkg::sample_type  out_im,
   input  logic                  csr_we,
   input  rnco_pkg::csr_addr_type csr_addr,
   input  rnco_pkg::csr_data_type csr_wdata
);
   import rnco_pkg::*;

   // Configuration and oscillator state
   logic       bypass_ff, bypass_in;
   osc_type    rot_cos_ff, rot_cos_in;
   osc_type    rot_sin_ff, rot_sin_in;
   osc_type    ph_re_ff, ph_re_in;
   osc_type    ph_im_ff, ph_im_in;
   logic       csr_hit;

   // Working registers
   sample_type samp_re_ff, samp_re_in;
   sample_type samp_im_ff, samp_im_in;
   osc_type    mul_a, mul_b;
   prod_type   prod_ff, prod_in;
   acc_type    acc_ff, acc_in;
   acc_type    prod_ext;
   acc_type    acc_sh;
   osc_type    osc_re_ff, osc_re_in;
   osc_type    osc_im_ff, osc_im_in;
   osc_type    g_ff, g_in;
   sample_type y_re_ff, y_re_in;
   sample_type y_im_ff, y_im_in;
   sample_type out_re_ff, out_re_in;
   sample_type out_im_ff, out_im_in;

   // Control that follows the product down the pipe
   logic [1:0] acc_op_d1_ff;
   logic [2:0] dst_d1_ff;
   logic [2:0] dst_d2_ff;

   // Decode register writes; an index beyond the list is dropped
   always_comb begin
      bypass_in  = bypass_ff;
      rot_cos_in = rot_cos_ff;
      rot_sin_in = rot_sin_ff;
      csr_hit    = 1'b0;
      if (csr_we) begin
         case (csr_addr)
            REG_BYPASS: begin
               bypass_in = csr_wdata[0];
               csr_hit   = 1'b1;
            end
            REG_ROT_COS: begin
               rot_cos_in = osc_type'(csr_wdata);
               csr_hit    = 1'b1;
            end
            REG_ROT_SIN: begin
               rot_sin_in = osc_type'(csr_wdata);
               csr_hit    = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
   end

   // Capture the sample on acceptance
   always_comb begin
      samp_re_in = cmd.take_sample ? in_re : samp_re_ff;
      samp_im_in = cmd.take_sample ? in_im : samp_im_ff;
   end

   // Select multiplier operands; samples widen to oscillator width
   always_comb begin
      case (cmd.mop.mul_sel)
         MUL_PR_PR: begin
            mul_a = ph_re_ff;
            mul_b = ph_re_ff;
         end
         MUL_PI_PI: begin
            mul_a = ph_im_ff;
            mul_b = ph_im_ff;
         end
         MUL_PR_RC: begin
            mul_a = ph_re_ff;
            mul_b = rot_cos_ff;
         end
         MUL_PI_RS: begin
            mul_a = ph_im_ff;
            mul_b = rot_sin_ff;
         end
         MUL_PR_RS: begin
            mul_a = ph_re_ff;
            mul_b = rot_sin_ff;
         end
         MUL_PI_RC: begin
            mul_a = ph_im_ff;
            mul_b = rot_cos_ff;
         end
         MUL_G_ORE: begin
            mul_a = g_ff;
            mul_b = osc_re_ff;
         end
         MUL_ORE_SR: begin
            mul_a = osc_re_ff;
            mul_b = OSC_BITS'(samp_re_ff);
         end
         MUL_OIM_SI: begin
            mul_a = osc_im_ff;
            mul_b = OSC_BITS'(samp_im_ff);
         end
         MUL_G_OIM: begin
            mul_a = g_ff;
            mul_b = osc_im_ff;
         end
         MUL_ORE_SI: begin
            mul_a = osc_re_ff;
            mul_b = OSC_BITS'(samp_im_ff);
         end
         MUL_OIM_SR: begin
            mul_a = osc_im_ff;
            mul_b = OSC_BITS'(samp_re_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   // Accumulate the registered product exactly
   always_comb begin
      prod_ext = ACC_BITS'(prod_ff);
      case (acc_op_d1_ff)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   // Floor the finished sum and write it back, saturated
   always_comb begin
      acc_sh    = acc_ff >>> OSC_FRAC_BITS;
      g_in      = g_ff;
      osc_re_in = osc_re_ff;
      osc_im_in = osc_im_ff;
      y_re_in   = y_re_ff;
      y_im_in   = y_im_ff;
      ph_re_in  = ph_re_ff;
      ph_im_in  = ph_im_ff;
      case (dst_d2_ff)
         DST_G:      g_in      = sat_osc(K195 - acc_sh);
         DST_OSC_RE: osc_re_in = sat_osc(acc_sh);
         DST_OSC_IM: osc_im_in = sat_osc(acc_sh);
         DST_PH_RE:  ph_re_in  = sat_osc(acc_sh);
         DST_PH_IM:  ph_im_in  = sat_osc(acc_sh);
         DST_Y_RE:   y_re_in   = sat_sample(acc_sh);
         DST_Y_IM:   y_im_in   = sat_sample(acc_sh);
         default:    g_in      = g_ff;
      endcase
      // Restart the oscillator on any write to a listed register
      if (csr_hit) begin
         ph_re_in = ONE_OSC;
         ph_im_in = '0;
      end
   end

   // Load the output register; bypass passes the sample unchanged
   always_comb begin
      out_re_in = out_re_ff;
      out_im_in = out_im_ff;
      if (cmd.publish) begin
         out_re_in = bypass_ff ? samp_re_ff : y_re_ff;
         out_im_in = bypass_ff ? samp_im_ff : y_im_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff    <= 1'b1;
         rot_cos_ff   <= ONE_OSC;
         rot_sin_ff   <= '0;
         ph_re_ff     <= ONE_OSC;
         ph_im_ff     <= '0;
         acc_op_d1_ff <= ACC_HOLD;
         dst_d1_ff    <= DST_NONE;
         dst_d2_ff    <= DST_NONE;
      end else begin
         bypass_ff    <= bypass_in;
         rot_cos_ff   <= rot_cos_in;
         rot_sin_ff   <= rot_sin_in;
         ph_re_ff     <= ph_re_in;
         ph_im_ff     <= ph_im_in;
         acc_op_d1_ff <= cmd.mop.acc_op;
         dst_d1_ff    <= cmd.mop.dst;
         dst_d2_ff    <= dst_d1_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      samp_re_ff <= samp_re_in;
      samp_im_ff <= samp_im_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      g_ff       <= g_in;
      osc_re_ff  <= osc_re_in;
      osc_im_ff  <= osc_im_in;
      y_re_ff    <= y_re_in;
      y_im_ff    <= y_im_in;
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
   end

   assign stat.bypass = bypass_ff;
   assign out_re      = out_re_ff;
   assign out_im      = out_im_ff;

endmodule

// File: src/rnco_ctrl.sv
// ----------------------------------------------------------------------------
// rnco_ctrl
// Sequencer for the mixer: accepts a sample, steps the datapath through its
// micro-operations and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "recursive_nco_complex_mixer_unit_macros.svh"

module rnco_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rnco_pkg::stat_type stat,
   output rnco_pkg::cmd_type  cmd
);
   import rnco_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RUN     = 2'd1;
   localparam logic [1:0] ST_PUBLISH = 2'd2;

   logic [1:0] state_ff, state_in;
   step_type   step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Sequence one transaction
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      cmd.take_sample = 1'b0;
      cmd.publish     = 1'b0;
      cmd.mop         = MOP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.take_sample = 1'b1;
               step_in         = '0;
               state_in        = stat.bypass ? ST_PUBLISH : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.mop = step_mop(step_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(NUM_STEPS - 1)) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            // Hold until the output register is free or being emptied
            if (!out_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Track the output register
   always_comb begin
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   `RNCO_ASSERT(a_no_overwrite, clock, reset, out_valid_ff && !rsp_ready |-> !cmd.publish, "result overwritten before it was taken")
   `RNCO_ASSERT(a_mix_starts, clock, reset, accept && !stat.bypass |=> state_ff == ST_RUN && step_ff == '0, "mixing did not start at step zero")
   `RNCO_ASSERT(a_step_range, clock, reset, state_ff == ST_RUN |-> step_ff < STEP_BITS'(NUM_STEPS), "step counter out of range")
   `RNCO_ASSERT(a_publish_shows, clock, reset, cmd.publish |=> rsp_valid, "published result not presented")
   `RNCO_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid && state_ff == ST_IDLE, "reset left work pending")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the recursive NCO complex mixer
// A table of directed transactions (bypass, unity step, quarter-turn steps,
// output and oscillator saturation, an unused register index), then random
// retuning and random samples. Each result is checked field by field against
// its typed value or a bit-accurate model of the gain-corrected oscillator.
// ----------------------------------------------------------------------------
module testbench;
   import rnco_pkg::*;

   localparam int OSC_FRAC       = 30;
   localparam int OSC_W          = 32;
   localparam int SMP_W          = 16;
   localparam int ITEMS_PER_MODE = 610;
   localparam int TAIL_CYCLES    = 24;
   localparam int CYCLE_LIMIT    = 500000;

   // Index beyond the register list: accepted, but has no effect
   localparam csr_addr_type REG_SPARE = 2'd3;

   typedef logic signed [71:0] wide_type;

   localparam wide_type GAIN_TARGET =
      ((wide_type'(39) <<< OSC_FRAC) + wide_type'(10)) / wide_type'(20);
   localparam osc_type UNITY     = 32'sh4000_0000;

   typedef struct packed {
      sample_type re;
      sample_type im;
   } sample_pair_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_MIX, ROW_LIT} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      csr_addr_type addr;
      csr_data_type data;
      sample_type   in_re;
      sample_type   in_im;
      sample_type   out_re;
      sample_type   out_im;
   } row_type;

   logic clock = 1'b0;
   logic reset;

   rnco_req_if req_bus ();
   rnco_rsp_if rsp_bus ();
   rnco_csr_if csr_bus ();

   recursive_nco_complex_mixer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Mixer model state
   logic    mixer_bypass;
   osc_type step_cos;
   osc_type step_sin;
   osc_type phase_re;
   osc_type phase_im;

   sample_pair_type expected_mix_q [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   bit              req_busy       = 1'b0;
   bit              csr_busy       = 1'b0;

   // Directed transactions; ROW_LIT rows carry the result typed in
   row_type directed_rows [35] = '{
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sh8000,
        16'sh7FFF,   16'sh8000},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sh8000,    16'sh7FFF,
        16'sh8000,   16'sh7FFF},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sd1,       -16'sd1,
        16'sd1,      -16'sd1},
      '{ROW_WRITE, REG_BYPASS,  32'hFFFF_FFFE, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sh8000,
        16'sh7FFF,   16'sh8000},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh8000,    16'sh8000,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sh7FFF,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_ROT_COS, 32'h0,         16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sd12345,   -16'sd2222,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sh8000,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_ROT_SIN, 32'h4000_0000, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sd100,     16'sd200,
        -16'sd200,   16'sd100},
      '{ROW_WRITE, REG_ROT_SIN, 32'h4000_0000, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sh8000,    16'sh8000,
        16'sh7FFF,   16'sh8000},
      '{ROW_WRITE, REG_ROT_SIN, 32'hC000_0000, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sd300,     -16'sd5,
        -16'sd5,     -16'sd300},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sd300,     -16'sd5,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         -16'sd7000,   16'sd9000,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_ROT_COS, 32'h7FFF_FFFF, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_ROT_SIN, 32'h8000_0000, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sh7FFF,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sh8000,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh8000,    16'sh7FFF,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sd1234,    -16'sd4321,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_SPARE,   32'hDEAD_BEEF, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sd2000,    -16'sd3000,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         -16'sd1,      -16'sd1,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_ROT_COS, 32'd1068378526, 16'sd0,      16'sd0,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_ROT_SIN, 32'd107195302, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh7FFF,    16'sd0,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sd0,       16'sh7FFF,
        16'sd0,      16'sd0},
      '{ROW_MIX,   REG_BYPASS,  32'h0,         16'sh8000,    16'sd0,
        16'sd0,      16'sd0},
      '{ROW_WRITE, REG_BYPASS,  32'h0000_0001, 16'sd0,       16'sd0,
        16'sd0,      16'sd0},
      '{ROW_LIT,   REG_BYPASS,  32'h0,         16'sd4321,    -16'sd1234,
        16'sd4321,   -16'sd1234}
   };

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Clamp a wide value to a signed range of the given width
   function automatic wide_type clamp_to(input wide_type x, input int bits);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (bits - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      if (x > hi) begin
         return hi;
      end
      if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

   // Rotate the phasor one step, apply the gain correction, mix one sample
   function automatic sample_pair_type mix_sample(input sample_type s_re,
                                                  input sample_type s_im);
      wide_type        ph_re, ph_im, rc, rs, sr, si;
      wide_type        osc_re, osc_im, mag, gain;
      sample_pair_type y;
      if (mixer_bypass) begin
         y.re = s_re;
         y.im = s_im;
         return y;
      end
      ph_re  = phase_re;
      ph_im  = phase_im;
      rc     = step_cos;
      rs     = step_sin;
      sr     = s_re;
      si     = s_im;
      osc_re = clamp_to((ph_re * rc - ph_im * rs) >>> OSC_FRAC, OSC_W);
      osc_im = clamp_to((ph_re * rs + ph_im * rc) >>> OSC_FRAC, OSC_W);
      mag    = (ph_re * ph_re + ph_im * ph_im) >>> OSC_FRAC;
      gain   = clamp_to(GAIN_TARGET - mag, OSC_W);
      phase_re = osc_type'(clamp_to((gain * osc_re) >>> OSC_FRAC, OSC_W));
      phase_im = osc_type'(clamp_to((gain * osc_im) >>> OSC_FRAC, OSC_W));
      y.re = sample_type'(clamp_to((osc_re * sr - osc_im * si) >>> OSC_FRAC, SMP_W));
      y.im = sample_type'(clamp_to((osc_re * si + osc_im * sr) >>> OSC_FRAC, SMP_W));
      return y;
   endfunction

   // Track a register write; any listed register also restarts the phasor
   function automatic void apply_reg_write(input csr_addr_type addr, input csr_data_type data);
      case (addr)
         REG_BYPASS: begin
            mixer_bypass = data[0];
         end
         REG_ROT_COS: begin
            step_cos = data;
         end
         REG_ROT_SIN: begin
            step_sin = data;
         end
         default: begin
            return;
         end
      endcase
      phase_re = UNITY;
      phase_im = '0;
   endfunction

   // Drop the sample valid and hold until every result has been taken
   task automatic drain_results();
      if (req_busy) begin
         req_bus.valid <= 1'b0;
         req_busy = 1'b0;
      end
      while (expected_mix_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write one register while the mixer is idle
   task automatic write_reg(input csr_addr_type addr, input csr_data_type data);
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_busy = 1'b1;
      apply_reg_write(addr, data);
   endtask

   // Offer one sample, with random idle cycles first, and record its result
   task automatic send_sample(input sample_type s_re, input sample_type s_im,
                              input bit typed_in, input sample_pair_type typed_result);
      sample_pair_type predicted;
      if (csr_busy) begin
         csr_bus.valid <= 1'b0;
         csr_busy = 1'b0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_re <= s_re;
      req_bus.in_im <= s_im;
      do @(posedge clock); while (!req_bus.ready);
      req_busy  = 1'b1;
      predicted = mix_sample(s_re, s_im);
      expected_mix_q.push_back(typed_in ? typed_result : predicted);
   endtask

   // New bypass setting and often a new phase step, mostly a true rotation
   task automatic retune_mixer();
      csr_data_type c, s, b;
      real          ang;
      b    = $urandom;
      b[0] = ($urandom_range(99) < 15);
      write_reg(REG_BYPASS, b);
      case ($urandom_range(9))
         7: begin
            c = $urandom;
            s = $urandom;
         end
         8: begin
            c = $urandom_range(32'h8000_0000) - 32'h4000_0000;
            s = $urandom_range(32'h8000_0000) - 32'h4000_0000;
         end
         9: begin
            case ($urandom_range(4))
               0: c = 32'h4000_0000;
               1: c = 32'hC000_0000;
               2: c = 32'h0;
               3: c = 32'h7FFF_FFFF;
               default: c = 32'h8000_0000;
            endcase
            case ($urandom_range(4))
               0: s = 32'h4000_0000;
               1: s = 32'hC000_0000;
               2: s = 32'h0;
               3: s = 32'h7FFF_FFFF;
               default: s = 32'h8000_0000;
            endcase
         end
         default: begin
            ang = ($itor($urandom_range(62830)) - 31415.0) / 10000.0;
            if ($urandom_range(2) == 0) begin
               ang = ang / 100.0;
            end
            c = $rtoi($cos(ang) * 1073741824.0);
            s = $rtoi($sin(ang) * 1073741824.0);
         end
      endcase
      if ($urandom_range(4) != 0) begin
         write_reg(REG_ROT_COS, c);
      end
      if ($urandom_range(4) != 0) begin
         write_reg(REG_ROT_SIN, s);
      end
      if ($urandom_range(9) == 0) begin
         write_reg(REG_SPARE, $urandom);
      end
   endtask

   // Check each result transaction and drive the result ready at random
   always @(posedge clock) begin : result_check
      sample_pair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_mix_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual (%0d, %0d)",
                     $time, rsp_bus.out_re, rsp_bus.out_im);
            mismatch_count++;
         end else begin
            want = expected_mix_q.pop_front();
            if (rsp_bus.out_re !== want.re) begin
               $display("%0t: out_re mismatch, expected %0d, actual %0d",
                        $time, want.re, rsp_bus.out_re);
               mismatch_count++;
            end
            if (rsp_bus.out_im !== want.im) begin
               $display("%0t: out_im mismatch, expected %0d, actual %0d",
                        $time, want.im, rsp_bus.out_im);
               mismatch_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      sample_type s_re, s_im;
      int         sent;
      int         seg_len;
      int         pick;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.in_re <= '0;
      req_bus.in_im <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.addr  <= '0;
      csr_bus.wdata <= '0;
      mixer_bypass  = 1'b1;
      step_cos      = UNITY;
      step_sin      = '0;
      phase_re      = UNITY;
      phase_im      = '0;
      send_idle_pct = 35;
      recv_idle_pct = 47;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            write_reg(directed_rows[r].addr, directed_rows[r].data);
         end else begin
            send_sample(directed_rows[r].in_re, directed_rows[r].in_im,
                        directed_rows[r].kind == ROW_LIT,
                        '{re: directed_rows[r].out_re, im: directed_rows[r].out_im});
         end
      end

      // Random segments under three idle patterns
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_MODE) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
               retune_mixer();
            end else if (pick == 7) begin
               drain_results();
            end
            seg_len = $urandom_range(120, 10);
            if (seg_len > ITEMS_PER_MODE - sent) begin
               seg_len = ITEMS_PER_MODE - sent;
            end
            for (int i = 0; i < seg_len; i++) begin
               case ($urandom_range(7))
                  0: begin
                     s_re = ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
                     s_im = ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
                  end
                  1: begin
                     s_re = sample_type'($urandom_range(512) - 256);
                     s_im = sample_type'($urandom_range(512) - 256);
                  end
                  default: begin
                     s_re = sample_type'($urandom);
                     s_im = sample_type'($urandom);
                  end
               endcase
               send_sample(s_re, s_im, 1'b0, '0);
            end
            sent += seg_len;
         end
      end

      // Let the last results arrive and watch for strays
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/rnco_pkg.sv
src/rnco_if.sv
src/rnco_datapath.sv
src/rnco_ctrl.sv
src/recursive_nco_complex_mixer_unit.sv
tb/testbench.sv
